// ===== rtl/scaled_hypotenuse_core_assert.svh =====
// ----------------------------------------------------------------------------
// scaled hypotenuse core assertion macros
// property wrappers that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SCALED_HYPOTENUSE_CORE_ASSERT_SVH
`define SCALED_HYPOTENUSE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// implication in the same cycle
`define SHC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication into the next cycle
`define SHC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define SHC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define SHC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/hyp_pkg.sv =====
// ----------------------------------------------------------------------------
// hyp_pkg
// shared constants and control types of the scaled hypotenuse core
// ----------------------------------------------------------------------------
package hyp_pkg;

   // fraction bits of the ratio w and of the root r
   localparam int RATIO_BITS   = 30;
   // width of the tiny threshold register
   localparam int THRESH_WIDTH = 16;
   // width of the square-root operand and partial root
   localparam int SQRT_WIDTH   = 2 * RATIO_BITS + 2;

   // control word that walks alongside the data in every cell
   typedef struct packed {
      logic valid;
      logic zero;   // result forced to zero (tiny sum or both zero)
      logic equal;  // magnitudes equal, ratio is exactly one
   } hyp_ctl_type;

endpackage

// ===== rtl/hyp_div_cell.sv =====
// ----------------------------------------------------------------------------
// hyp_div_cell
// one restoring division step of the ratio small / big, registered
// ----------------------------------------------------------------------------
module hyp_div_cell
   import hyp_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  hyp_ctl_type             in_ctl,
   input  logic [DATA_WIDTH-1:0]   in_rem,
   input  logic [RATIO_BITS-1:0]   in_quot,
   input  logic [DATA_WIDTH-1:0]   in_big,
   output hyp_ctl_type             out_ctl,
   output logic [DATA_WIDTH-1:0]   out_rem,
   output logic [RATIO_BITS-1:0]   out_quot,
   output logic [DATA_WIDTH-1:0]   out_big
);

   hyp_ctl_type             ctl_ff;
   logic [DATA_WIDTH-1:0]   rem_ff, rem_in;
   logic [RATIO_BITS-1:0]   quot_ff, quot_in;
   logic [DATA_WIDTH-1:0]   big_ff;
   logic [DATA_WIDTH:0]     shifted;
   logic [DATA_WIDTH:0]     diff;

   // shift in one bit and try to subtract the divisor
   always_comb begin
      shifted = {in_rem, 1'b0};
      diff    = shifted - {1'b0, in_big};
      if (shifted >= {1'b0, in_big}) begin
         rem_in  = diff[DATA_WIDTH-1:0];
         quot_in = {in_quot[RATIO_BITS-2:0], 1'b1};
      end else begin
         rem_in  = shifted[DATA_WIDTH-1:0];
         quot_in = {in_quot[RATIO_BITS-2:0], 1'b0};
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= in_ctl;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         big_ff  <= in_big;
      end
   end

   assign out_ctl  = ctl_ff;
   assign out_rem  = rem_ff;
   assign out_quot = quot_ff;
   assign out_big  = big_ff;

endmodule

// ===== rtl/hyp_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// hyp_sqrt_cell
// one digit step of the bitwise integer square root, registered
// ----------------------------------------------------------------------------
module hyp_sqrt_cell
   import hyp_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int BIT_POS    = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  hyp_ctl_type             in_ctl,
   input  logic [SQRT_WIDTH-1:0]   in_rad,
   input  logic [SQRT_WIDTH-1:0]   in_root,
   input  logic [DATA_WIDTH-1:0]   in_big,
   output hyp_ctl_type             out_ctl,
   output logic [SQRT_WIDTH-1:0]   out_rad,
   output logic [SQRT_WIDTH-1:0]   out_root,
   output logic [DATA_WIDTH-1:0]   out_big
);

   localparam logic [SQRT_WIDTH:0] BitVal = (SQRT_WIDTH+1)'(1) << (2 * BIT_POS);

   hyp_ctl_type             ctl_ff;
   logic [SQRT_WIDTH-1:0]   rad_ff, rad_in;
   logic [SQRT_WIDTH-1:0]   root_ff, root_in;
   logic [DATA_WIDTH-1:0]   big_ff;
   logic [SQRT_WIDTH:0]     trial;
   logic [SQRT_WIDTH:0]     left;

   // compare remainder with root plus bit
   always_comb begin
      trial = {1'b0, in_root} + BitVal;
      left  = {1'b0, in_rad} - trial;
      if ({1'b0, in_rad} >= trial) begin
         rad_in  = left[SQRT_WIDTH-1:0];
         root_in = (in_root >> 1) + BitVal[SQRT_WIDTH-1:0];
      end else begin
         rad_in  = in_rad;
         root_in = in_root >> 1;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= in_ctl;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (enable) begin
         rad_ff  <= rad_in;
         root_ff <= root_in;
         big_ff  <= in_big;
      end
   end

   assign out_ctl  = ctl_ff;
   assign out_rad  = rad_ff;
   assign out_root = root_ff;
   assign out_big  = big_ff;

endmodule

// ===== rtl/scaled_hypotenuse_core.sv =====
// ----------------------------------------------------------------------------
// scaled_hypotenuse_core
// overflow-free two-operand norm, big * sqrt(1 + (small/big)^2)
// ----------------------------------------------------------------------------
// Takes one word of two signed operands per cycle unless stalled and returns one
// unsigned magnitude word per word, in order, with the same binary point as the
// inputs. Results are zero when |x| + |y| is below tiny_threshold (reset 1) or
// both operands are zero. The datapath is a fixed pipeline: one magnitude stage,
// a row of 30 division cells, one squaring stage, a row of 31 square-root cells,
// one multiply stage and the output register for the default 30-bit ratio, and a
// new word is taken every cycle while not stalled. The whole row stalls together
// while a finished word waits on rsp_ready.
// ----------------------------------------------------------------------------
`include "scaled_hypotenuse_core_assert.svh"

module scaled_hypotenuse_core
   import hyp_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_first_value,
   input  logic signed [DATA_WIDTH-1:0] req_second_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [DATA_WIDTH-1:0]        rsp_magnitude,
   input  logic                         csr_write_enable,
   input  logic [THRESH_WIDTH-1:0]      csr_write_data
);

   // binary point is shared by inputs and result, raw math ignores it
   localparam int PointPos = FRAC_BITS;
   localparam int SumWidth = (DATA_WIDTH + 1 > THRESH_WIDTH) ? DATA_WIDTH + 1 : THRESH_WIDTH;
   localparam int BigWidth = (DATA_WIDTH > RATIO_BITS) ? DATA_WIDTH : RATIO_BITS + 1;
   localparam int HiWidth  = BigWidth - RATIO_BITS;
   localparam int RootW    = RATIO_BITS + 1;
   localparam int HiProdW  = HiWidth + RootW;
   localparam int LoProdW  = RATIO_BITS + RootW;
   localparam int ResW     = (HiProdW > DATA_WIDTH) ? HiProdW + 1 : DATA_WIDTH + 1;

   logic                     enable;
   logic [THRESH_WIDTH-1:0]  tiny_threshold_ff;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         tiny_threshold_ff <= THRESH_WIDTH'(1);
      end else if (csr_write_enable) begin
         tiny_threshold_ff <= csr_write_data;
      end
   end

   // whole pipeline advances unless the output word is held
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   // magnitude stage
   logic [DATA_WIDTH-1:0]  mag_u, mag_v, big_in, small_in;
   logic [SumWidth-1:0]    sum_uv;
   hyp_ctl_type            ctl_a_in, ctl_a_ff;
   logic [DATA_WIDTH-1:0]  big_a_ff, small_a_ff;

   always_comb begin
      mag_u    = req_first_value[DATA_WIDTH-1]  ? (~req_first_value + 1'b1)  : req_first_value;
      mag_v    = req_second_value[DATA_WIDTH-1] ? (~req_second_value + 1'b1) : req_second_value;
      big_in   = (mag_u >= mag_v) ? mag_u : mag_v;
      small_in = (mag_u >= mag_v) ? mag_v : mag_u;
      sum_uv   = SumWidth'(mag_u) + SumWidth'(mag_v);
      ctl_a_in.valid = req_valid;
      ctl_a_in.zero  = (sum_uv < SumWidth'(tiny_threshold_ff)) || (big_in == '0);
      ctl_a_in.equal = (mag_u == mag_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
      end else if (enable) begin
         ctl_a_ff <= ctl_a_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         big_a_ff   <= big_in;
         small_a_ff <= small_in;
      end
   end

   // division row
   hyp_ctl_type            div_ctl  [0:RATIO_BITS];
   logic [DATA_WIDTH-1:0]  div_rem  [0:RATIO_BITS];
   logic [RATIO_BITS-1:0]  div_quot [0:RATIO_BITS];
   logic [DATA_WIDTH-1:0]  div_big  [0:RATIO_BITS];

   assign div_ctl[0]  = ctl_a_ff;
   assign div_rem[0]  = small_a_ff;
   assign div_quot[0] = '0;
   assign div_big[0]  = big_a_ff;

   for (genvar i = 0; i < RATIO_BITS; i++) begin : g_div
      hyp_div_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .in_ctl   (div_ctl[i]),
         .in_rem   (div_rem[i]),
         .in_quot  (div_quot[i]),
         .in_big   (div_big[i]),
         .out_ctl  (div_ctl[i+1]),
         .out_rem  (div_rem[i+1]),
         .out_quot (div_quot[i+1]),
         .out_big  (div_big[i+1])
      );
   end

   // squaring stage, s = 1.0 + w*w
   logic [RATIO_BITS:0]      ratio_w;
   logic [2*RATIO_BITS+1:0]  square_w;
   logic [SQRT_WIDTH-1:0]    rad_in, rad_b_ff;
   hyp_ctl_type              ctl_b_ff;
   logic [DATA_WIDTH-1:0]    big_b_ff;

   always_comb begin
      ratio_w  = div_ctl[RATIO_BITS].equal ? (RATIO_BITS+1)'(1) << RATIO_BITS
                                           : {1'b0, div_quot[RATIO_BITS]};
      square_w = ratio_w * ratio_w;
      rad_in   = SQRT_WIDTH'(square_w) + (SQRT_WIDTH'(1) << (2 * RATIO_BITS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff <= '0;
      end else if (enable) begin
         ctl_b_ff <= div_ctl[RATIO_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rad_b_ff <= rad_in;
         big_b_ff <= div_big[RATIO_BITS];
      end
   end

   // square-root row, radicand is at least 1.0 so the top digit is fixed
   hyp_ctl_type            sq_ctl  [0:RATIO_BITS+1];
   logic [SQRT_WIDTH-1:0]  sq_rad  [0:RATIO_BITS+1];
   logic [SQRT_WIDTH-1:0]  sq_root [0:RATIO_BITS+1];
   logic [DATA_WIDTH-1:0]  sq_big  [0:RATIO_BITS+1];

   assign sq_ctl[0]  = ctl_b_ff;
   assign sq_rad[0]  = rad_b_ff;
   assign sq_root[0] = '0;
   assign sq_big[0]  = big_b_ff;

   for (genvar k = 0; k <= RATIO_BITS; k++) begin : g_sqrt
      hyp_sqrt_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .BIT_POS    (RATIO_BITS - k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .in_ctl   (sq_ctl[k]),
         .in_rad   (sq_rad[k]),
         .in_root  (sq_root[k]),
         .in_big   (sq_big[k]),
         .out_ctl  (sq_ctl[k+1]),
         .out_rad  (sq_rad[k+1]),
         .out_root (sq_root[k+1]),
         .out_big  (sq_big[k+1])
      );
   end

   // multiply stage, big split at the ratio point
   logic [RootW-1:0]       root_r;
   logic [BigWidth-1:0]    big_ext;
   logic [HiProdW-1:0]     prod_hi_in, prod_hi_ff;
   logic [LoProdW-1:0]     prod_lo_in, prod_lo_ff;
   hyp_ctl_type            ctl_c_ff;

   always_comb begin
      root_r     = sq_root[RATIO_BITS+1][RootW-1:0];
      big_ext    = BigWidth'(sq_big[RATIO_BITS+1]);
      prod_hi_in = big_ext[BigWidth-1:RATIO_BITS] * root_r;
      prod_lo_in = big_ext[RATIO_BITS-1:0] * root_r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_c_ff <= '0;
      end else if (enable) begin
         ctl_c_ff <= sq_ctl[RATIO_BITS+1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_hi_ff <= prod_hi_in;
         prod_lo_ff <= prod_lo_in;
      end
   end

   // output register
   logic [ResW-1:0]        result_sum;
   logic                   rsp_valid_ff;
   logic [DATA_WIDTH-1:0]  rsp_magnitude_ff, rsp_magnitude_in;

   always_comb begin
      result_sum = ResW'(prod_hi_ff) + ResW'(prod_lo_ff >> RATIO_BITS);
      rsp_magnitude_in = ctl_c_ff.zero ? '0 : result_sum[DATA_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= ctl_c_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_magnitude_ff <= rsp_magnitude_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = rsp_magnitude_ff;

   // checks
   logic point_unused;
   assign point_unused = (PointPos < 0);

   `SHC_ASSERT_NEXT(a_stall_holds, clock, reset, !enable, $stable(ctl_a_ff) && !point_unused)
   `SHC_ASSERT_NEXT(a_zero_word, clock, reset, enable && ctl_c_ff.valid && ctl_c_ff.zero, rsp_magnitude == '0)
   `SHC_ASSERT_IMPL(a_root_floor, clock, reset, sq_ctl[RATIO_BITS+1].valid, root_r[RATIO_BITS] == 1'b1)

endmodule

// ===== test/tb_scaled_hypotenuse_core.sv =====
// ----------------------------------------------------------------------------
// tb_scaled_hypotenuse_core
// self-checking bench for the scaled hypotenuse core
// ----------------------------------------------------------------------------
// Operand words go in through a queue-fed driver with random gaps. A monitor
// with random backpressure compares every magnitude word, in order, against a
// bit-exact integer predictor. The threshold is reprogrammed between phases
// while the pipeline is drained.
// ----------------------------------------------------------------------------
module tb_scaled_hypotenuse_core
   import hyp_pkg::*;
();

   localparam int DW = 32;
   localparam int PIPE_DEPTH = 65;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [DW-1:0] req_first_value = '0;
   logic signed [DW-1:0] req_second_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [DW-1:0] rsp_magnitude;
   logic csr_write_enable = 1'b0;
   logic [THRESH_WIDTH-1:0] csr_write_data = '0;

   typedef struct packed {
      logic [DW-1:0] x;
      logic [DW-1:0] y;
   } operand_word_type;

   operand_word_type pending_words[$];
   logic [DW-1:0] expected_magnitudes[$];
   logic [THRESH_WIDTH-1:0] tiny_bound;
   int mismatch_count = 0;
   int idle_cycles = 0;
   int gap_left = 0;
   int stall_left = 0;

   always #5 clock = ~clock;

   scaled_hypotenuse_core #(.DATA_WIDTH(DW), .FRAC_BITS(16)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_first_value(req_first_value), .req_second_value(req_second_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_magnitude(rsp_magnitude),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   // two's complement magnitude, most negative value stays exact
   function automatic logic [63:0] abs_of(logic [DW-1:0] raw);
      if (raw[DW-1]) return {32'b0, (~raw + 1'b1)};
      return {32'b0, raw};
   endfunction

   // norm of one operand pair under the current threshold
   function automatic logic [DW-1:0] norm_of(logic [DW-1:0] x, logic [DW-1:0] y);
      logic [63:0] u, v, big, sml, w, rem, s, r, rbit, n;
      u = abs_of(x);
      v = abs_of(y);
      big = (u >= v) ? u : v;
      sml = (u >= v) ? v : u;
      if (u + v < {48'b0, tiny_bound} || big == 0) return '0;
      // restoring division into a q1.30 ratio
      if (sml >= big) w = 64'd1 << RATIO_BITS;
      else begin
         w = 0;
         rem = sml;
         for (int i = 0; i < RATIO_BITS; i++) begin
            rem = rem << 1;
            w = w << 1;
            if (rem >= big) begin
               rem = rem - big;
               w[0] = 1'b1;
            end
         end
      end
      s = (64'd1 << (2 * RATIO_BITS)) + w * w;
      // digit-by-digit integer square root
      n = s;
      r = 0;
      rbit = 64'd1 << 62;
      while (rbit > n) rbit = rbit >> 2;
      while (rbit != 0) begin
         if (n >= r + rbit) begin
            n = n - (r + rbit);
            r = (r >> 1) + rbit;
         end else r = r >> 1;
         rbit = rbit >> 2;
      end
      return DW'((big >> RATIO_BITS) * r + (((big & ((64'd1 << RATIO_BITS) - 1)) * r)
         >> RATIO_BITS));
   endfunction

   function automatic int random_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   function automatic logic [DW-1:0] random_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return DW'($urandom_range(0, 8)) - 32'd4;
         3: return DW'($urandom_range(0, 65535)) ^ {32{$urandom_range(0, 1) == 1}};
         default: return $urandom;
      endcase
   endfunction

   // driver: one word from the queue, held until accepted
   always @(posedge clock) begin : p_driver
      int next_gap;
      if (!reset) begin
         if (req_valid && req_ready) begin
            void'(pending_words.pop_front());
            next_gap = random_gap();
            // zero gap: next word follows directly
            if (next_gap == 0 && pending_words.size() > 0) begin
               req_first_value <= pending_words[0].x;
               req_second_value <= pending_words[0].y;
               expected_magnitudes.push_back(norm_of(pending_words[0].x,
                                                    pending_words[0].y));
               gap_left <= 0;
            end else begin
               gap_left <= next_gap;
               req_valid <= 1'b0;
            end
         end else if (!req_valid) begin
            if (gap_left > 0) gap_left <= gap_left - 1;
            else if (pending_words.size() > 0) begin
               req_first_value <= pending_words[0].x;
               req_second_value <= pending_words[0].y;
               expected_magnitudes.push_back(norm_of(pending_words[0].x,
                                                    pending_words[0].y));
               req_valid <= 1'b1;
            end
         end
      end
   end

   // monitor: random backpressure and in-order compare
   always @(posedge clock) begin
      if (!reset) begin
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 4) == 0) stall_left <= random_gap();
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_magnitudes.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10) $display("unexpected word %h", rsp_magnitude);
            end else begin
               if (rsp_magnitude !== expected_magnitudes[0]) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("magnitude mismatch: expected %h actual %h",
                              expected_magnitudes[0], rsp_magnitude);
               end
               void'(expected_magnitudes.pop_front());
            end
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic add_word(logic [DW-1:0] x, logic [DW-1:0] y);
      operand_word_type item;
      item.x = x;
      item.y = y;
      pending_words.push_back(item);
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || req_valid || expected_magnitudes.size() > 0)
         @(posedge clock);
      repeat (PIPE_DEPTH + 5) @(posedge clock);
   endtask

   task automatic set_threshold(logic [THRESH_WIDTH-1:0] bound);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= bound;
      tiny_bound = bound;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_words(int count);
      for (int i = 0; i < count; i++) add_word(random_operand(), random_operand());
   endtask

   initial begin
      tiny_bound = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, equal magnitudes, zeros, reset threshold edge
      add_word(0, 0);
      add_word(1, 0);
      add_word(0, 32'hffff_ffff);
      add_word(32'h8000_0000, 32'h8000_0000);
      add_word(32'h7fff_ffff, 32'h7fff_ffff);
      add_word(32'h8000_0000, 32'h7fff_ffff);
      add_word(32'h7fff_ffff, 0);
      add_word(32'h0003_0000, 32'hfffc_0000);
      add_word(32'h0001_0000, 32'hffff_0000);
      add_word(32'hffff_ffff, 32'h8000_0000);
      add_word(32'h0000_0001, 32'h7fff_ffff);
      add_word(32'haaaa_aaaa, 32'h5555_5555);
      drain();

      // zero threshold: both-zero case with no division
      set_threshold(0);
      add_word(0, 0);
      add_word(32'h8000_0000, 0);
      random_words(60);
      drain();

      // largest threshold with sums just around it
      set_threshold(16'hffff);
      add_word(32'h0000_fffe, 0);
      add_word(32'h0000_7fff, 32'hffff_8001);
      add_word(32'h0000_ffff, 0);
      for (int i = 0; i < 60; i++)
         add_word(DW'($urandom_range(0, 65535)), -DW'($urandom_range(0, 65535)));
      drain();

      // mid thresholds and wide random operands
      set_threshold(16'h0100);
      random_words(140);
      drain();
      set_threshold(16'h5a5a);
      for (int i = 0; i < 40; i++)
         add_word(DW'($urandom_range(0, 40000)), DW'($urandom_range(0, 40000)));
      random_words(100);
      drain();

      if (mismatch_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
